FILE: hdl/mhrf_pkg.sv
// Shared types, constants and datapath command codes for the rest-interval finder.
// Used by mhrf_ctrl, mhrf_dp and motion_history_rest_finder; depends on nothing.
`timescale 1ns / 1ps
package mhrf_pkg;

  localparam int RING_MINUTES = 1440;
  localparam int RING_AW      = $clog2(RING_MINUTES);
  localparam int RING_W       = $clog2(RING_MINUTES + 1);

  // floor(x / 60) for any 32-bit x is (x * MIN_MAGIC) >> MIN_SHIFT.
  localparam logic [31:0] MIN_MAGIC = 32'h8888_8889;
  localparam int          MIN_SHIFT = 37;
  // floor(y / 60) for y below 4160 is (y * COV_MAGIC) >> COV_SHIFT.
  localparam int COV_MAGIC   = 2185;
  localparam int COV_SHIFT   = 17;
  localparam int SEC_PER_MIN = 60;
  localparam int MIN_ROUND   = 59;
  localparam int PCT_FULL    = 100;

  localparam int CFG_AW = 5;
  localparam logic [2:0] REG_SENSOR_PRESENT = 3'd0;
  localparam logic [2:0] REG_REST_WINDOW    = 3'd1;
  localparam logic [2:0] REG_REST_PERCENT   = 3'd2;
  localparam logic [2:0] REG_REST_GAP       = 3'd3;
  localparam logic [2:0] REG_MIN_REST       = 3'd4;
  localparam logic [2:0] REG_WAKE_RUN       = 3'd5;

  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NOP     = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD    = 5'd1;
  localparam logic [OP_W-1:0] OP_MUL     = 5'd2;
  localparam logic [OP_W-1:0] OP_DEC     = 5'd3;
  localparam logic [OP_W-1:0] OP_PUSH    = 5'd4;
  localparam logic [OP_W-1:0] OP_AINIT   = 5'd5;
  localparam logic [OP_W-1:0] OP_PF_RD   = 5'd6;
  localparam logic [OP_W-1:0] OP_PF_WR   = 5'd7;
  localparam logic [OP_W-1:0] OP_RL_INIT = 5'd8;
  localparam logic [OP_W-1:0] OP_RL_RD   = 5'd9;
  localparam logic [OP_W-1:0] OP_RL_MUL  = 5'd10;
  localparam logic [OP_W-1:0] OP_RL_WR   = 5'd11;
  localparam logic [OP_W-1:0] OP_SC_INIT = 5'd12;
  localparam logic [OP_W-1:0] OP_SC_RD   = 5'd13;
  localparam logic [OP_W-1:0] OP_SC_EV   = 5'd14;
  localparam logic [OP_W-1:0] OP_CL_RD   = 5'd15;
  localparam logic [OP_W-1:0] OP_CL_EV   = 5'd16;
  localparam logic [OP_W-1:0] OP_WK_INIT = 5'd17;
  localparam logic [OP_W-1:0] OP_WK_RD   = 5'd18;
  localparam logic [OP_W-1:0] OP_WK_EV   = 5'd19;
  localparam logic [OP_W-1:0] OP_WK_FIN  = 5'd20;
  localparam logic [OP_W-1:0] OP_OUTC    = 5'd21;

  typedef struct packed {
    logic        operation;
    logic [31:0] now_seconds;
    logic        sensor_active;
  } in_item_t;

  typedef struct packed {
    logic        report_valid;
    logic [31:0] rest_start_seconds;
    logic [31:0] rest_end_seconds;
    logic [10:0] rest_duration;
    logic [10:0] still_count;
    logic [9:0]  wake_total;
    logic [4:0]  hours_covered;
    logic [31:0] last_motion_seconds;
  } out_item_t;

  typedef struct packed {
    logic        sensor_present;
    logic [7:0]  rest_window_minutes;
    logic [6:0]  rest_percent;
    logic [7:0]  rest_gap_minutes;
    logic [10:0] min_rest_minutes;
    logic [7:0]  wake_run_minutes;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic push_done;
    logic analyze;
    logic k_end;
    logic joining;
    logic close_now;
    logic cand;
    logic found;
    logic wk_done;
  } sts_t;

endpackage

FILE: hdl/mhrf_ctrl.sv
// Sequencer of the rest-interval finder: steps the datapath through sample,
// prefix, classify, scan, wake and report phases. Depends on mhrf_pkg.
`timescale 1ns / 1ps
module mhrf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          out_free,
  input  mhrf_pkg::sts_t sts,
  output logic          in_stall,
  output logic          out_load,
  output mhrf_pkg::cmd_t cmd
);
  import mhrf_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_MUL    = 5'd1;
  localparam logic [4:0] S_DEC    = 5'd2;
  localparam logic [4:0] S_PUSH   = 5'd3;
  localparam logic [4:0] S_AINIT  = 5'd4;
  localparam logic [4:0] S_PF_RD  = 5'd5;
  localparam logic [4:0] S_PF_WR  = 5'd6;
  localparam logic [4:0] S_RL_RD  = 5'd7;
  localparam logic [4:0] S_RL_MUL = 5'd8;
  localparam logic [4:0] S_RL_WR  = 5'd9;
  localparam logic [4:0] S_SC_RD  = 5'd10;
  localparam logic [4:0] S_SC_EV  = 5'd11;
  localparam logic [4:0] S_CL_RD  = 5'd12;
  localparam logic [4:0] S_CL_EV  = 5'd13;
  localparam logic [4:0] S_WK_RD  = 5'd14;
  localparam logic [4:0] S_WK_EV  = 5'd15;
  localparam logic [4:0] S_OUTC   = 5'd16;
  localparam logic [4:0] S_FIN    = 5'd17;

  logic [4:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NOP;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.op    = OP_DEC;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (!sts.push_done) begin
          cmd.op = OP_PUSH;
        end else if (sts.analyze) begin
          state_nxt = S_AINIT;
        end else begin
          state_nxt = S_OUTC;
        end
      end
      S_AINIT: begin
        cmd.op    = OP_AINIT;
        state_nxt = S_PF_RD;
      end
      S_PF_RD: begin
        if (sts.k_end) begin
          cmd.op    = OP_RL_INIT;
          state_nxt = S_RL_RD;
        end else begin
          cmd.op    = OP_PF_RD;
          state_nxt = S_PF_WR;
        end
      end
      S_PF_WR: begin
        cmd.op    = OP_PF_WR;
        state_nxt = S_PF_RD;
      end
      S_RL_RD: begin
        if (sts.k_end) begin
          cmd.op    = OP_SC_INIT;
          state_nxt = S_SC_RD;
        end else begin
          cmd.op    = OP_RL_RD;
          state_nxt = S_RL_MUL;
        end
      end
      S_RL_MUL: begin
        cmd.op    = OP_RL_MUL;
        state_nxt = S_RL_WR;
      end
      S_RL_WR: begin
        cmd.op    = OP_RL_WR;
        state_nxt = S_RL_RD;
      end
      S_SC_RD: begin
        if (!sts.k_end) begin
          cmd.op    = OP_SC_RD;
          state_nxt = S_SC_EV;
        end else if (sts.joining) begin
          state_nxt = S_CL_RD;
        end else if (sts.found) begin
          cmd.op    = OP_WK_INIT;
          state_nxt = S_WK_RD;
        end else begin
          state_nxt = S_OUTC;
        end
      end
      S_SC_EV: begin
        cmd.op    = OP_SC_EV;
        state_nxt = sts.close_now ? S_CL_RD : S_SC_RD;
      end
      S_CL_RD: begin
        cmd.op    = OP_CL_RD;
        state_nxt = sts.cand ? S_CL_EV : S_SC_RD;
      end
      S_CL_EV: begin
        cmd.op    = OP_CL_EV;
        state_nxt = S_SC_RD;
      end
      S_WK_RD: begin
        if (sts.wk_done) begin
          cmd.op    = OP_WK_FIN;
          state_nxt = S_OUTC;
        end else begin
          cmd.op    = OP_WK_RD;
          state_nxt = S_WK_EV;
        end
      end
      S_WK_EV: begin
        cmd.op    = OP_WK_EV;
        state_nxt = S_WK_RD;
      end
      S_OUTC: begin
        cmd.op    = OP_OUTC;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/mhrf_dp.sv
// Datapath of the rest-interval finder: activity ring, prefix-count and rest-flag
// memories, sample bookkeeping and interval scoring. Depends on mhrf_pkg.
`timescale 1ns / 1ps
module mhrf_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  mhrf_pkg::cmd_t    cmd,
  input  mhrf_pkg::in_item_t in_data,
  input  mhrf_pkg::cfg_t    cfg,
  output mhrf_pkg::sts_t    sts,
  output mhrf_pkg::out_item_t res
);
  import mhrf_pkg::*;

  localparam int XW = RING_W + 1;
  localparam int MW = RING_W + 7;
  localparam int CW = RING_W + 13;

  // Memories.
  logic              ring_mem [RING_MINUTES];
  logic [RING_W-1:0] p_mem    [RING_MINUTES + 1];
  logic              r_mem    [RING_MINUTES];
  logic              ring_rd_r, r_rd_r;
  logic [RING_W-1:0] pa_r, pb_r;

  // Control state (reset).
  logic [RING_AW-1:0] pos_r, pos_nxt;
  logic [RING_W-1:0]  fill_r, fill_nxt;
  logic [31:0]        prev_r, prev_nxt;
  logic [31:0]        motion_r, motion_nxt;
  logic [RING_W-1:0]  cnt_r, cnt_nxt;
  logic               join_r, join_nxt;
  logic               found_r, found_nxt;

  // Working registers.
  logic               op_r, op_nxt;
  logic [31:0]        now_r, now_nxt;
  logic               act_r, act_nxt;
  logic [63:0]        prod_r, prod_nxt;
  logic [RING_W-1:0]  k_r, k_nxt;
  logic [RING_W-1:0]  acc_r, acc_nxt;
  logic [XW-1:0]      span_r, span_nxt;
  logic               ok_r, ok_nxt;
  logic [MW-1:0]      m1_r, m1_nxt, m2_r, m2_nxt;
  logic [RING_W-1:0]  lo_r, lo_nxt, last_r, last_nxt;
  logic [RING_W-1:0]  hi_r, hi_nxt, dur_r, dur_nxt;
  logic [RING_W-1:0]  best_lo_r, best_lo_nxt, best_hi_r, best_hi_nxt;
  logic [RING_W-1:0]  best_st_r, best_st_nxt;
  logic [XW-1:0]      top_score_r, top_score_nxt;
  logic [RING_W-1:0]  run_r, run_nxt, wakes_r, wakes_nxt;
  out_item_t          res_r, res_nxt;

  // Combinational helpers.
  logic [31:0]        minute, gap, oldest_m;
  logic [RING_AW-1:0] oldest;
  logic [XW-1:0]      addr_sum, addr_wrap;
  logic [RING_AW-1:0] ring_addr;
  logic [XW-1:0]      kx, hx, lo_c, hi_c;
  logic               ok_c;
  logic [RING_W-1:0]  hi_cl, cl_dur, still_c;
  logic [XW-1:0]      score;
  logic               wake_hit;
  logic [CW-1:0]      cov_sum, cov_prod;
  logic [RING_W-1:0]  pa_addr, pb_addr, p_wa, p_wd;
  logic               p_we;

  assign minute   = 32'(prod_r >> MIN_SHIFT);
  assign gap      = minute - prev_r;
  assign oldest   = (fill_r == RING_W'(RING_MINUTES)) ? pos_r : '0;
  assign addr_sum = XW'(oldest) + XW'(k_r);
  assign addr_wrap = (addr_sum >= XW'(RING_MINUTES)) ? addr_sum - XW'(RING_MINUTES)
                                                     : addr_sum;
  assign ring_addr = addr_wrap[RING_AW-1:0];

  // Centered window around minute k, clipped to the recorded span.
  assign kx   = XW'(k_r);
  assign hx   = XW'(cfg.rest_window_minutes[7:1]);
  assign lo_c = (kx > hx) ? kx - hx : '0;
  always_comb begin
    hi_c = kx + hx;
    if (hi_c > XW'(fill_r)) begin
      hi_c = XW'(fill_r);
    end
  end
  assign ok_c = (hi_c >= lo_c) && ((hi_c - lo_c) >= hx);

  assign hi_cl    = last_r + RING_W'(1);
  assign cl_dur   = hi_cl - lo_r;
  assign still_c  = pb_r - pa_r;
  assign score    = XW'(dur_r) + XW'(still_c);
  assign wake_hit = (run_r != '0) && (32'(run_r) >= 32'(cfg.wake_run_minutes));
  assign cov_sum  = CW'(fill_r) + CW'(MIN_ROUND);
  assign cov_prod = cov_sum * CW'(COV_MAGIC);
  assign oldest_m = prev_r - 32'(fill_r) + 32'd1;

  assign pa_addr = (cmd.op == OP_CL_RD) ? lo_r  : lo_c[RING_W-1:0];
  assign pb_addr = (cmd.op == OP_CL_RD) ? hi_cl : hi_c[RING_W-1:0];
  assign p_we    = (cmd.op == OP_AINIT) || (cmd.op == OP_PF_WR);
  assign p_wa    = (cmd.op == OP_PF_WR) ? k_r + RING_W'(1) : '0;
  assign p_wd    = (cmd.op == OP_PF_WR) ? acc_nxt : '0;

  assign sts.push_done = (cnt_r == '0);
  assign sts.analyze   = op_r && (32'(fill_r) >= 32'(cfg.min_rest_minutes));
  assign sts.k_end     = (k_r >= fill_r);
  assign sts.joining   = join_r;
  assign sts.close_now = join_r && !r_rd_r &&
                         (32'(k_r - last_r) > 32'(cfg.rest_gap_minutes));
  assign sts.cand      = (32'(cl_dur) >= 32'(cfg.min_rest_minutes));
  assign sts.found     = found_r;
  assign sts.wk_done   = (k_r >= best_hi_r);

  assign res = res_r;

  always_comb begin
    pos_nxt = pos_r;   fill_nxt = fill_r;   prev_nxt = prev_r;
    motion_nxt = motion_r; cnt_nxt = cnt_r; join_nxt = join_r; found_nxt = found_r;
    op_nxt = op_r;     now_nxt = now_r;     act_nxt = act_r;   prod_nxt = prod_r;
    k_nxt = k_r;       acc_nxt = acc_r;     span_nxt = span_r; ok_nxt = ok_r;
    m1_nxt = m1_r;     m2_nxt = m2_r;       lo_nxt = lo_r;     last_nxt = last_r;
    hi_nxt = hi_r;     dur_nxt = dur_r;     best_lo_nxt = best_lo_r;
    best_hi_nxt = best_hi_r; best_st_nxt = best_st_r; top_score_nxt = top_score_r;
    run_nxt = run_r;   wakes_nxt = wakes_r; res_nxt = res_r;
    unique case (cmd.op)
      OP_LOAD: begin
        op_nxt    = in_data.operation;
        now_nxt   = in_data.now_seconds;
        act_nxt   = in_data.sensor_active;
        found_nxt = 1'b0;
      end
      OP_MUL: begin
        prod_nxt = 64'(now_r) * 64'(MIN_MAGIC);
      end
      OP_DEC: begin
        cnt_nxt = '0;
        if (cfg.sensor_present) begin
          if (act_r) begin
            motion_nxt = now_r;
          end
          if (prev_r == '1) begin
            cnt_nxt = RING_W'(1);
          end else if (minute < prev_r) begin
            pos_nxt  = '0;
            fill_nxt = '0;
            cnt_nxt  = RING_W'(1);
          end else if (minute > prev_r) begin
            if (gap > 32'(RING_MINUTES)) begin
              pos_nxt  = '0;
              fill_nxt = '0;
              cnt_nxt  = RING_W'(1);
            end else begin
              cnt_nxt = RING_W'(gap);
            end
          end
          prev_nxt = minute;
        end
      end
      OP_PUSH: begin
        if (cnt_r != '0) begin
          pos_nxt = (pos_r == RING_AW'(RING_MINUTES - 1)) ? '0 : pos_r + RING_AW'(1);
          if (fill_r != RING_W'(RING_MINUTES)) begin
            fill_nxt = fill_r + RING_W'(1);
          end
          cnt_nxt = cnt_r - RING_W'(1);
        end
      end
      OP_AINIT: begin
        k_nxt   = '0;
        acc_nxt = '0;
      end
      OP_PF_WR: begin
        acc_nxt = acc_r + RING_W'(!ring_rd_r);
        k_nxt   = k_r + RING_W'(1);
      end
      OP_RL_INIT: begin
        k_nxt = '0;
      end
      OP_RL_RD: begin
        span_nxt = hi_c - lo_c;
        ok_nxt   = ok_c;
      end
      OP_RL_MUL: begin
        m1_nxt = MW'(still_c) * MW'(PCT_FULL);
        m2_nxt = MW'(span_r) * MW'(cfg.rest_percent);
      end
      OP_RL_WR: begin
        k_nxt = k_r + RING_W'(1);
      end
      OP_SC_INIT: begin
        k_nxt          = '0;
        join_nxt       = 1'b0;
        found_nxt      = 1'b0;
        top_score_nxt  = '0;
        best_lo_nxt    = '0;
        best_hi_nxt    = '0;
        best_st_nxt    = '0;
      end
      OP_SC_EV: begin
        if (!join_r) begin
          if (r_rd_r) begin
            lo_nxt   = k_r;
            last_nxt = k_r;
            join_nxt = 1'b1;
          end
          k_nxt = k_r + RING_W'(1);
        end else if (r_rd_r) begin
          last_nxt = k_r;
          k_nxt    = k_r + RING_W'(1);
        end else if (!sts.close_now) begin
          k_nxt = k_r + RING_W'(1);
        end
      end
      OP_CL_RD: begin
        dur_nxt = cl_dur;
        hi_nxt  = hi_cl;
        if (!sts.cand) begin
          join_nxt = 1'b0;
        end
      end
      OP_CL_EV: begin
        join_nxt = 1'b0;
        if (score > top_score_r) begin
          top_score_nxt  = score;
          best_lo_nxt    = lo_r;
          best_hi_nxt    = hi_r;
          best_st_nxt    = still_c;
          found_nxt      = 1'b1;
        end
      end
      OP_WK_INIT: begin
        k_nxt     = best_lo_r;
        run_nxt   = '0;
        wakes_nxt = '0;
      end
      OP_WK_EV: begin
        if (ring_rd_r) begin
          run_nxt = run_r + RING_W'(1);
        end else begin
          if (wake_hit) begin
            wakes_nxt = wakes_r + RING_W'(1);
          end
          run_nxt = '0;
        end
        k_nxt = k_r + RING_W'(1);
      end
      OP_WK_FIN: begin
        if (wake_hit) begin
          wakes_nxt = wakes_r + RING_W'(1);
        end
      end
      OP_OUTC: begin
        res_nxt.report_valid        = found_r;
        res_nxt.rest_start_seconds  = found_r ?
            (oldest_m + 32'(best_lo_r)) * 32'(SEC_PER_MIN) : 32'd0;
        res_nxt.rest_end_seconds    = found_r ?
            (oldest_m + 32'(best_hi_r)) * 32'(SEC_PER_MIN) : 32'd0;
        res_nxt.rest_duration       = found_r ? 11'(best_hi_r - best_lo_r) : 11'd0;
        res_nxt.still_count         = found_r ? 11'(best_st_r) : 11'd0;
        res_nxt.wake_total          = found_r ? 10'(wakes_r) : 10'd0;
        res_nxt.hours_covered       = 5'(cov_prod >> COV_SHIFT);
        res_nxt.last_motion_seconds = motion_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      fill_r   <= '0;
      prev_r   <= '1;
      motion_r <= '0;
      cnt_r    <= '0;
      join_r   <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      fill_r   <= fill_nxt;
      prev_r   <= prev_nxt;
      motion_r <= motion_nxt;
      cnt_r    <= cnt_nxt;
      join_r   <= join_nxt;
      found_r  <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;     now_r <= now_nxt;   act_r <= act_nxt;   prod_r <= prod_nxt;
    k_r <= k_nxt;       acc_r <= acc_nxt;   span_r <= span_nxt; ok_r <= ok_nxt;
    m1_r <= m1_nxt;     m2_r <= m2_nxt;     lo_r <= lo_nxt;     last_r <= last_nxt;
    hi_r <= hi_nxt;     dur_r <= dur_nxt;   best_lo_r <= best_lo_nxt;
    best_hi_r <= best_hi_nxt; best_st_r <= best_st_nxt; top_score_r <= top_score_nxt;
    run_r <= run_nxt;   wakes_r <= wakes_nxt; res_r <= res_nxt;
  end

  // Activity ring: one bit per minute, written at the write position.
  always_ff @(posedge clk) begin
    if ((cmd.op == OP_PUSH) && (cnt_r != '0)) begin
      ring_mem[pos_r] <= act_r;
    end
    if ((cmd.op == OP_PF_RD) || (cmd.op == OP_WK_RD)) begin
      ring_rd_r <= ring_mem[ring_addr];
    end
  end

  // Prefix counts of still minutes, entry i covers offsets below i.
  always_ff @(posedge clk) begin
    if (p_we) begin
      p_mem[p_wa] <= p_wd;
    end
    if ((cmd.op == OP_RL_RD) || (cmd.op == OP_CL_RD)) begin
      pa_r <= p_mem[pa_addr];
      pb_r <= p_mem[pb_addr];
    end
  end

  // Rest-like flag for each offset.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_RL_WR) begin
      r_mem[k_r[RING_AW-1:0]] <= ok_r && (m1_r >= m2_r);
    end
    if (cmd.op == OP_SC_RD) begin
      r_rd_r <= r_mem[k_r[RING_AW-1:0]];
    end
  end

endmodule

FILE: hdl/motion_history_rest_finder.sv
// Rest-interval finder over a one-bit-per-minute activity history: top level with
// configuration registers, result register and the sequencer/datapath pair.
// Depends on mhrf_pkg, mhrf_ctrl and mhrf_dp.
`timescale 1ns / 1ps
// The block records one activity bit per minute for the last 1440 minutes and
// answers every input item with exactly one result item. A sample tick fills one
// ring entry per elapsed minute (at most 1440 after a long gap). An analyze item
// then works on the F recorded minutes in passes over on-chip memories: a prefix
// count of still minutes, a rest classification of every minute (a prefix-memory
// read pair, two registered products, then a flag write), an interval scan that
// also scores each closed interval, and a wake count over the best interval. One
// item is worked on at a time; the next item is taken as soon as the result has
// moved into the output register, even while that result still waits for the
// receiver. No clearing pass is needed after reset: the ring is read only at
// offsets below the fill count. Configuration should be written only while the
// block is idle.
module motion_history_rest_finder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  mhrf_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output mhrf_pkg::out_item_t         out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [mhrf_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import mhrf_pkg::*;

  cfg_t      cfg_r;
  cmd_t      cmd;
  sts_t      sts;
  out_item_t res;
  out_item_t out_data_r;
  logic      out_valid_r;
  logic      out_free, out_load;
  logic      cfg_wr;
  logic [2:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[4:2];

  // Register file; unused data bits of each register read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sensor_present      <= 1'b1;
      cfg_r.rest_window_minutes <= 8'd30;
      cfg_r.rest_percent        <= 7'd80;
      cfg_r.rest_gap_minutes    <= 8'd10;
      cfg_r.min_rest_minutes    <= 11'd60;
      cfg_r.wake_run_minutes    <= 8'd5;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SENSOR_PRESENT: cfg_r.sensor_present      <= cfg_pwdata[0];
        REG_REST_WINDOW:    cfg_r.rest_window_minutes <= cfg_pwdata[7:0];
        REG_REST_PERCENT:   cfg_r.rest_percent        <= cfg_pwdata[6:0];
        REG_REST_GAP:       cfg_r.rest_gap_minutes    <= cfg_pwdata[7:0];
        REG_MIN_REST:       cfg_r.min_rest_minutes    <= cfg_pwdata[10:0];
        REG_WAKE_RUN:       cfg_r.wake_run_minutes    <= cfg_pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SENSOR_PRESENT: cfg_prdata = 32'(cfg_r.sensor_present);
      REG_REST_WINDOW:    cfg_prdata = 32'(cfg_r.rest_window_minutes);
      REG_REST_PERCENT:   cfg_prdata = 32'(cfg_r.rest_percent);
      REG_REST_GAP:       cfg_prdata = 32'(cfg_r.rest_gap_minutes);
      REG_MIN_REST:       cfg_prdata = 32'(cfg_r.min_rest_minutes);
      REG_WAKE_RUN:       cfg_prdata = 32'(cfg_r.wake_run_minutes);
      default:            cfg_prdata = 32'd0;
    endcase
  end

  // The output register frees up in the same cycle its item is taken.
  assign out_free = !out_valid_r || !out_stall;

  mhrf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .sts      (sts),
    .in_stall (in_stall),
    .out_load (out_load),
    .cmd      (cmd)
  );

  mhrf_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_data (in_data),
    .cfg     (cfg_r),
    .sts     (sts),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
